@@ design/assert_macros.svh @@
// Assertion macros shared by the sweep smallest-object finder RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ssof_pkg.sv @@
// Types, constants and the half-degree sine table for the sweep finder.
// No dependencies.
package ssof_pkg;

    localparam int MAX_SAMPLES      = 128;
    localparam int MAX_OBJECTS_KEPT = 15;
    localparam int FOUND_MAX        = 15;

    localparam int SAMPLE_ADDR_W = $clog2(MAX_SAMPLES);
    localparam int SAMPLE_CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int OBJ_IDX_W     = $clog2(MAX_OBJECTS_KEPT);
    localparam int OBJ_CNT_W     = $clog2(MAX_OBJECTS_KEPT + 1);

    localparam int DVD_W  = 9;
    localparam int DVS_W  = 8;
    localparam int SINE_W = 17;
    localparam int SINE_N = 181;
    localparam int PROD_W = 8 + SINE_W + 1;

    localparam logic [1:0] CFG_RANGE_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_MATCH_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_ANGLE_STEP      = 2'd2;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic [7:0] sample_angle;
        logic [7:0] ir_range;
        logic [7:0] sonar_range;
        logic       sweep_end;
    } ssof_item_t;

    typedef struct packed {
        logic [7:0] target_angle;
        logic [7:0] target_width;
        logic [3:0] objects_found;
    } ssof_result_t;

    typedef struct packed {
        logic [7:0] range_limit;
        logic [7:0] match_tolerance;
        logic [6:0] angle_step;
    } ssof_cfg_t;

    typedef struct packed {
        logic [OBJ_CNT_W-1:0]    object_total;
        logic [SAMPLE_CNT_W-1:0] sample_count;
    } ssof_status_t;

    typedef logic [SINE_W-1:0] sine_tab_t [SINE_N];

    // Taylor series in Q2.30, evaluated at elaboration only
    function automatic sine_tab_t build_sine();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        for (int k = 0; k < SINE_N; k++)
        begin
            x    = (64'(k) * PI_Q30) / 64'd360;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 6; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            r = (64'(sum) + 64'd8192) >> 14;
            if (r > 64'd65536)
                r = 64'd65536;
            tab[k] = r[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

@@ design/ssof_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ssof_pkg.
module ssof_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [ssof_pkg::DVD_W-1:0] dividend,
    input  logic [ssof_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [ssof_pkg::DVD_W-1:0] quotient
);
    import ssof_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVD_W-1:0] r_sh;
    logic             fits;

    assign r_sh = {rem_reg[DVD_W-2:0], quo_reg[DVD_W-1]};
    assign fits = (r_sh >= {{(DVD_W-DVS_W){1'b0}}, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? (r_sh - {{(DVD_W-DVS_W){1'b0}}, dvs_reg}) : r_sh;
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/ssof_collect.sv @@
// Segmentation of the sweep, object angle lists and sonar sample memory.
// Depends on ssof_pkg.
module ssof_collect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_go,
    input  ssof_pkg::ssof_item_t              item,
    input  ssof_pkg::ssof_cfg_t               cfg,
    input  logic                              sweep_clr,
    input  logic [ssof_pkg::OBJ_IDX_W-1:0]    obj_sel,
    input  logic                              rd_en,
    input  logic [ssof_pkg::SAMPLE_ADDR_W-1:0] rd_addr,
    output ssof_pkg::ssof_status_t            status,
    output logic [7:0]                        sel_start,
    output logic [7:0]                        sel_end,
    output logic [7:0]                        rd_data
);
    import ssof_pkg::*;

    logic [7:0] sonar_mem [MAX_SAMPLES];
    logic [7:0] start_mem [MAX_OBJECTS_KEPT];
    logic [7:0] end_mem   [MAX_OBJECTS_KEPT];
    logic [7:0] rd_data_reg;

    logic [7:0]              prev_ir_reg;
    logic [7:0]              prev_angle_reg;
    logic                    have_prev_reg;
    logic                    in_object_reg;
    logic [OBJ_CNT_W-1:0]    total_reg;
    logic [SAMPLE_CNT_W-1:0] count_reg;

    logic [7:0] diff;
    logic       cur_in;
    logic       open_hit;
    logic       close_hit;
    logic       room;
    logic       store_ok;

    assign diff   = (prev_ir_reg >= item.ir_range) ? prev_ir_reg - item.ir_range
                                                   : item.ir_range - prev_ir_reg;
    assign cur_in = prev_ir_reg < cfg.range_limit;
    assign room   = 32'(total_reg) < MAX_OBJECTS_KEPT;
    assign open_hit  = have_prev_reg && !in_object_reg && cur_in
                       && (diff < cfg.match_tolerance);
    assign close_hit = have_prev_reg && in_object_reg && cur_in
                       && (item.ir_range >= cfg.range_limit);
    assign store_ok  = 32'(count_reg) < MAX_SAMPLES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ir_reg    <= '0;
            prev_angle_reg <= '0;
            have_prev_reg  <= 1'b0;
            in_object_reg  <= 1'b0;
            total_reg      <= '0;
            count_reg      <= '0;
        end
        else if (sweep_clr)
        begin
            have_prev_reg <= 1'b0;
            in_object_reg <= 1'b0;
            total_reg     <= '0;
            count_reg     <= '0;
        end
        else if (item_go)
        begin
            if (open_hit)
            begin
                if (room)
                    in_object_reg <= 1'b1;
            end
            else if (close_hit)
            begin
                if (room)
                    total_reg <= total_reg + 1'b1;
                in_object_reg <= 1'b0;
            end
            if (store_ok)
                count_reg <= count_reg + 1'b1;
            prev_ir_reg    <= item.ir_range;
            prev_angle_reg <= item.sample_angle;
            have_prev_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_go && open_hit && room)
            start_mem[total_reg[OBJ_IDX_W-1:0]] <= prev_angle_reg;
        if (item_go && !open_hit && close_hit && room)
            end_mem[total_reg[OBJ_IDX_W-1:0]] <= prev_angle_reg;
    end

    always_ff @(posedge clk)
    begin
        if (item_go && store_ok)
            sonar_mem[count_reg[SAMPLE_ADDR_W-1:0]] <= item.sonar_range;
        if (rd_en)
            rd_data_reg <= sonar_mem[rd_addr];
    end

    assign status.object_total = total_reg;
    assign status.sample_count = count_reg;
    assign sel_start = start_mem[obj_sel];
    assign sel_end   = end_mem[obj_sel];
    assign rd_data   = rd_data_reg;

endmodule

@@ design/sweep_smallest_object_finder_unit.sv @@
// Sweep smallest-object finder, top level: config registers and final-pass sequencer.
// Depends on ssof_pkg, ssof_collect, ssof_divider and assert_macros.svh.
//
//   channel   signals                         beat taken when
//   sample    start, busy, item               start && !busy
//   result    done, result                    done (one cycle, no stall)
//   config    cfg_we, cfg_idx, cfg_wdata      cfg_we
//
// A sample without sweep_end is taken with busy staying low.
// A sample with sweep_end raises busy until every kept object has been scored;
// each object costs one pass of the 9-step shared divider, a sonar read,
// one multiply and one compare. done pulses in the cycle busy drops.
// Reset clears control state only; no memory clearing pass.
module sweep_smallest_object_finder_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  ssof_pkg::ssof_item_t   item,
    output logic                   done,
    output ssof_pkg::ssof_result_t result,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [7:0]             cfg_wdata
);
    import ssof_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    ssof_cfg_t    cfg_reg;
    ssof_status_t status;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [OBJ_CNT_W-1:0] obj_reg;
    logic [7:0]           best_w_reg;
    logic [7:0]           best_a_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 done_reg;
    ssof_result_t         result_reg;

    logic                     item_go;
    logic                     sweep_clr;
    logic                     div_go;
    logic                     div_done;
    logic [DVD_W-1:0]         quotient;
    logic [7:0]               sel_start;
    logic [7:0]               sel_end;
    logic [7:0]               rd_data;
    logic                     rd_en;
    logic [SAMPLE_ADDR_W-1:0] rd_addr;
    logic [DVD_W-1:0]         angle_sum;
    logic [DVS_W-1:0]         divisor;
    logic [6:0]               step;
    logic [7:0]               span;
    logic [7:0]               k;
    logic [31:0]              idx_clamped;
    logic [9:0]               w_full;
    logic [7:0]               w_sat;
    logic                     more;

    assign item_go   = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign more      = obj_reg < status.object_total;
    assign sweep_clr = (state_reg == S_SCAN) && !more;
    assign div_go    = (state_reg == S_SCAN) && more;
    assign rd_en     = state_reg == S_RD;

    assign angle_sum = {1'b0, sel_start} + {1'b0, sel_end};
    assign step      = (cfg_reg.angle_step == 7'd0) ? 7'd1 : cfg_reg.angle_step;
    assign divisor   = {step, 1'b0};

    assign idx_clamped = (32'(quotient) >= 32'(status.sample_count))
                         ? 32'(status.sample_count) - 32'd1 : 32'(quotient);
    assign rd_addr     = idx_clamped[SAMPLE_ADDR_W-1:0];

    assign span = (sel_end >= sel_start) ? sel_end - sel_start : sel_start - sel_end;
    assign k    = (span <= 8'd180) ? span : 8'(9'd360 - {1'b0, span});

    assign w_full = prod_reg[PROD_W-1:16];
    assign w_sat  = (w_full > 10'd255) ? 8'd255 : w_full[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_limit     <= 8'd50;
            cfg_reg.match_tolerance <= 8'd3;
            cfg_reg.angle_step      <= 7'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_RANGE_LIMIT:     cfg_reg.range_limit     <= cfg_wdata;
                CFG_MATCH_TOLERANCE: cfg_reg.match_tolerance <= cfg_wdata;
                CFG_ANGLE_STEP:      cfg_reg.angle_step      <= cfg_wdata[6:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (item_go && item.sweep_end) state_next = S_SCAN;
            S_SCAN: state_next = more ? S_DIV : S_IDLE;
            S_DIV:  if (div_done) state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_CMP;
            S_CMP:  state_next = S_SCAN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            obj_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= sweep_clr;
            if (state_reg == S_IDLE)
                obj_reg <= '0;
            else if (state_reg == S_CMP)
                obj_reg <= obj_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_go && item.sweep_end)
        begin
            best_w_reg <= 8'd255;
            best_a_reg <= 8'd255;
        end
        else if (state_reg == S_CMP && w_sat < best_w_reg)
        begin
            best_w_reg <= w_sat;
            best_a_reg <= angle_sum[DVD_W-1:1];
        end
        if (state_reg == S_MUL)
            prod_reg <= {(PROD_W-1)'(rd_data * SINE_TAB[k]), 1'b0};
        if (sweep_clr)
        begin
            result_reg.target_angle  <= best_a_reg;
            result_reg.target_width  <= best_w_reg;
            result_reg.objects_found <= (32'(status.object_total) > FOUND_MAX)
                                        ? 4'(FOUND_MAX) : 4'(status.object_total);
        end
    end

    ssof_collect u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_go   (item_go),
        .item      (item),
        .cfg       (cfg_reg),
        .sweep_clr (sweep_clr),
        .obj_sel   (obj_reg[OBJ_IDX_W-1:0]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .status    (status),
        .sel_start (sel_start),
        .sel_end   (sel_end),
        .rd_data   (rd_data)
    );

    ssof_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (angle_sum),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPLY(a_done_single, clk, rst_n, done, $past(state_reg) == S_SCAN)
    `ASSERT_IMPLY(a_rd_after_div, clk, rst_n, state_reg == S_RD, $past(div_done))
    `ASSERT_IMPLY(a_obj_bound, clk, rst_n, busy, obj_reg <= status.object_total)

endmodule

@@ sim/sweep_smallest_object_finder_unit_tb.sv @@
// Self-checking testbench for the sweep smallest-object finder: directed and random sweeps,
// with a scoreboard that predicts each end-of-sweep target beat from the accepted samples.
// Depends on ssof_pkg and sweep_smallest_object_finder_unit.
module sweep_smallest_object_finder_unit_tb;

    import ssof_pkg::*;

    localparam int CYCLE_LIMIT  = 2500000;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 140;

    class target_scoreboard;
        bit [7:0]     range_limit;
        bit [7:0]     match_tol;
        bit [6:0]     angle_step;
        bit [7:0]     sonar_mem [MAX_SAMPLES];
        bit [7:0]     obj_start [MAX_OBJECTS_KEPT];
        bit [7:0]     obj_end [MAX_OBJECTS_KEPT];
        bit [7:0]     last_ir;
        bit [7:0]     last_angle;
        bit           seen_prev;
        bit           open_obj;
        int unsigned  obj_count;
        int unsigned  stored;
        int unsigned  sine_lut [181];
        ssof_result_t expected_targets [$];
        int           errors;

        function new();
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] term;
            bit [63:0] r;
            bit [63:0] div;
            longint    acc;
            range_limit = 8'd50;
            match_tol   = 8'd3;
            angle_step  = 7'd2;
            // Q2.30 Taylor series, half-degree steps, rounded to Q1.16
            for (int k = 0; k < 181; k++)
            begin
                x    = 64'(k);
                x    = (x * PI_Q30) / 64'd360;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int n = 1; n <= 6; n++)
                begin
                    div  = 64'((2 * n) * (2 * n + 1));
                    term = ((term * x2) >> 30) / div;
                    if ((n % 2) == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                r = 64'(acc);
                r = (r + 64'd8192) >> 14;
                if (r > 64'd65536)
                    r = 64'd65536;
                sine_lut[k] = r[31:0];
            end
        endfunction

        function void write_reg(bit [1:0] idx, bit [7:0] v);
            case (idx)
                CFG_RANGE_LIMIT:     range_limit = v;
                CFG_MATCH_TOLERANCE: match_tol   = v;
                CFG_ANGLE_STEP:      angle_step  = v[6:0];
                default: ;
            endcase
        endfunction

        function void pair_check(bit [7:0] cur, bit [7:0] cur_ang, bit [7:0] nxt);
            bit [7:0] diff;
            diff = (cur >= nxt) ? cur - nxt : nxt - cur;
            if (!open_obj && cur < range_limit && diff < match_tol)
            begin
                if (obj_count < MAX_OBJECTS_KEPT)
                begin
                    obj_start[obj_count] = cur_ang;
                    open_obj = 1'b1;
                end
            end
            else if (open_obj && cur < range_limit && nxt >= range_limit)
            begin
                if (obj_count < MAX_OBJECTS_KEPT)
                begin
                    obj_end[obj_count] = cur_ang;
                    obj_count++;
                end
                open_obj = 1'b0;
            end
        endfunction

        function void note_sample(ssof_item_t it);
            int unsigned  step;
            int unsigned  idx;
            int unsigned  s;
            int unsigned  e;
            int unsigned  span;
            int unsigned  k;
            int unsigned  w;
            int unsigned  best_w;
            int unsigned  best_a;
            bit [63:0]    prod;
            ssof_result_t tgt;
            if (seen_prev)
                pair_check(last_ir, last_angle, it.ir_range);
            if (stored < MAX_SAMPLES)
            begin
                sonar_mem[stored] = it.sonar_range;
                stored++;
            end
            last_ir    = it.ir_range;
            last_angle = it.sample_angle;
            seen_prev  = 1'b1;
            if (it.sweep_end)
            begin
                step   = (angle_step == 7'd0) ? 32'd1 : 32'(angle_step);
                best_w = 255;
                best_a = 255;
                for (int i = 0; i < obj_count; i++)
                begin
                    s   = 32'(obj_start[i]);
                    e   = 32'(obj_end[i]);
                    idx = (s + e) / (2 * step);
                    if (idx >= stored)
                        idx = stored - 1;
                    span = (e >= s) ? e - s : s - e;
                    k    = (span <= 180) ? span : 360 - span;
                    prod = 64'(sonar_mem[idx]);
                    prod = (prod * 2 * sine_lut[k]) >> 16;
                    w    = (prod > 255) ? 32'd255 : prod[31:0];
                    if (w < best_w)
                    begin
                        best_w = w;
                        best_a = (s + e) / 2;
                    end
                end
                tgt.target_angle  = best_a[7:0];
                tgt.target_width  = best_w[7:0];
                tgt.objects_found = obj_count[3:0];
                expected_targets.push_back(tgt);
                seen_prev = 1'b0;
                open_obj  = 1'b0;
                obj_count = 0;
                stored    = 0;
            end
        endfunction

        function void check_target(ssof_result_t got);
            ssof_result_t exp_r;
            if (expected_targets.size() == 0)
            begin
                $display("%0t: target beat with none pending: expected none, got %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = expected_targets.pop_front();
                if (got.target_angle !== exp_r.target_angle)
                begin
                    $display("%0t: target_angle expected %0d got %0d",
                             $time, exp_r.target_angle, got.target_angle);
                    errors++;
                end
                if (got.target_width !== exp_r.target_width)
                begin
                    $display("%0t: target_width expected %0d got %0d",
                             $time, exp_r.target_width, got.target_width);
                    errors++;
                end
                if (got.objects_found !== exp_r.objects_found)
                begin
                    $display("%0t: objects_found expected %0d got %0d",
                             $time, exp_r.objects_found, got.objects_found);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         start     = 1'b0;
    logic         busy;
    ssof_item_t   item      = '0;
    logic         done;
    ssof_result_t result;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_idx   = CFG_RANGE_LIMIT;
    logic [7:0]   cfg_wdata = 8'd0;

    target_scoreboard sb = new();
    int burst_left;
    int items_sent;
    int cycles;
    bit quiet;

    sweep_smallest_object_finder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_target(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sweep_smallest_object_finder_unit] ERROR");
            $finish;
        end
    end

    function automatic ssof_item_t mk(int a, int ir, int so, bit last);
        ssof_item_t it;
        it.sample_angle = 8'(a);
        it.ir_range     = 8'(ir);
        it.sonar_range  = 8'(so);
        it.sweep_end    = last;
        return it;
    endfunction

    // one sample beat, with burst/gap pacing on the sender side
    task automatic send_beat(input ssof_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            if (quiet)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 40);
            else
                gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_sample(it);
        burst_left--;
        items_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.expected_targets.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic program_config(input int p);
        logic [7:0] rl;
        logic [7:0] tol;
        logic [7:0] st;
        case (p)
            1:
            begin
                rl = 8'd255; tol = 8'd255; st = 8'd1;
            end
            2:
            begin
                rl = 8'd0;   tol = 8'd0;   st = 8'd127;
            end
            3:
            begin
                rl = 8'd1;   tol = 8'd1;   st = 8'd0;
            end
            4:
            begin
                rl = 8'd200; tol = 8'd10;  st = 8'd90;
            end
            13:
            begin
                rl = 8'd50;  tol = 8'd3;   st = 8'd2;
            end
            default:
            begin
                rl  = 8'($urandom_range(20, 255));
                tol = 8'($urandom_range(1, 15));
                st  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 127))
                                                  : 8'($urandom_range(1, 8));
            end
        endcase
        cfg_write(CFG_RANGE_LIMIT, rl);
        cfg_write(CFG_MATCH_TOLERANCE, tol);
        cfg_write(CFG_ANGLE_STEP, st);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_sweeps();
        send_beat(mk(0, 0, 0, 1));
        send_beat(mk(0, 10, 250, 0));
        send_beat(mk(2, 11, 5, 0));
        send_beat(mk(4, 12, 6, 0));
        send_beat(mk(6, 60, 7, 0));
        send_beat(mk(8, 200, 8, 1));
        // object still open at the end of the sweep
        send_beat(mk(180, 20, 1, 0));
        send_beat(mk(170, 21, 1, 0));
        send_beat(mk(160, 22, 250, 1));
        // span past 180 degrees, index clamped to last stored sample
        send_beat(mk(0, 5, 3, 0));
        send_beat(mk(250, 5, 3, 0));
        send_beat(mk(255, 255, 3, 0));
        send_beat(mk(10, 49, 0, 1));
        // saturated width is never picked
        send_beat(mk(0, 1, 250, 0));
        send_beat(mk(90, 2, 250, 0));
        send_beat(mk(180, 3, 250, 0));
        send_beat(mk(90, 255, 250, 1));
    endtask

    task automatic run_sweep();
        int         len;
        int         r;
        bit         dense;
        bit         wild;
        bit         obj_run;
        int         run_left;
        int         ir_v;
        int         rl;
        int         tol;
        int         step;
        int         a0;
        int         delta;
        int         ang;
        ssof_item_t it;
        r = $urandom_range(0, 19);
        if (r == 0)
            len = 1;
        else if (r < 3)
            len = $urandom_range(100, 220);
        else
            len = $urandom_range(2, 40);
        dense    = ($urandom_range(0, 3) == 0);
        wild     = ($urandom_range(0, 7) == 0);
        rl       = int'(sb.range_limit);
        tol      = int'(sb.match_tol);
        step     = (sb.angle_step == 7'd0) ? 1 : int'(sb.angle_step);
        if ($urandom_range(0, 4) == 0)
            step = $urandom_range(1, 6);
        a0       = $urandom_range(0, 30);
        obj_run  = 1'b0;
        run_left = $urandom_range(0, 3);
        ir_v     = 0;
        for (int pos = 0; pos < len; pos++)
        begin
            if (run_left == 0)
            begin
                obj_run = !obj_run;
                if (obj_run)
                begin
                    run_left = dense ? $urandom_range(2, 3) : $urandom_range(2, 10);
                    ir_v     = (rl == 0) ? 0 : $urandom_range(0, rl - 1);
                end
                else
                    run_left = dense ? 1 : $urandom_range(1, 6);
            end
            run_left--;
            if (wild || $urandom_range(0, 9) == 0)
                it.ir_range = 8'($urandom_range(0, 255));
            else if (obj_run && rl != 0)
            begin
                delta = (tol > 1) ? $urandom_range(0, tol - 1) : 0;
                ir_v  = $urandom_range(0, 1) ? ir_v + delta : ir_v - delta;
                if (ir_v < 0)
                    ir_v = 0;
                if (ir_v > rl - 1)
                    ir_v = rl - 1;
                it.ir_range = 8'(ir_v);
            end
            else
                it.ir_range = 8'($urandom_range(rl, 255));
            ang = a0 + pos * step;
            if (ang > 180)
                ang = 180;
            it.sample_angle = wild ? 8'($urandom_range(0, 255)) : 8'(ang);
            it.sonar_range  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 250))
                                                          : 8'($urandom_range(0, 40));
            it.sweep_end    = (pos == len - 1);
            send_beat(it);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                program_config(p);
            quiet = ((p % 4) == 3);
            if (p == 0)
                directed_sweeps();
            while (items_sent < (p + 1) * PHASE_ITEMS)
                run_sweep();
            wait_idle();
        end
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("[sweep_smallest_object_finder_unit] OK");
        else
            $display("[sweep_smallest_object_finder_unit] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/ssof_pkg.sv
design/ssof_divider.sv
design/ssof_collect.sv
design/sweep_smallest_object_finder_unit.sv
sim/sweep_smallest_object_finder_unit_tb.sv
